// File: src/spdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdq_pkg
// shared types and constants of the strict priority queue with cancel
// ----------------------------------------------------------------------------
package spdq_pkg;

    localparam int NUM_LEVELS_DEF  = 4;
    localparam int POOL_DEPTH_DEF  = 16;
    localparam int HANDLE_BITS_DEF = 8;
    localparam int LEVEL_BITS      = 2;
    localparam int TAG_BITS        = 8;
    localparam int TYPE_BITS       = 2;
    localparam int STATUS_BITS     = 2;

    typedef enum logic [TYPE_BITS-1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP        = 2'd2,
        REQ_CANCEL     = 2'd3
    } req_type_t;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                 ins_front;  // insert at head of level
        logic                 ins_back;   // insert at tail of level
        logic                 pop_head;   // remove head of level
        logic                 cancel;     // remove all matching of level
        logic [LEVEL_BITS-1:0] level;
        logic [TAG_BITS-1:0]   tag;
    } cell_cmd_t;

endpackage

// File: src/spdq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdq_req_if / spdq_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface spdq_req_if #(parameter int HANDLE_BITS = 8);
    logic                   valid;
    logic                   ready;
    logic [1:0]             req_type;
    logic [1:0]             level;
    logic [HANDLE_BITS-1:0] handle;
    logic [7:0]             tag_key;
    modport source (output valid, req_type, level, handle, tag_key, input ready);
    modport sink   (input valid, req_type, level, handle, tag_key, output ready);
endinterface

interface spdq_rsp_if #(parameter int HANDLE_BITS = 8);
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic                   got_entry;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [1:0]             out_level;
    logic [4:0]             removed;
    logic [4:0]             occupancy;
    modport source (output valid, status, got_entry, out_handle, out_level, removed,
                    occupancy, input ready);
    modport sink   (input valid, status, got_entry, out_handle, out_level, removed,
                    occupancy, output ready);
endinterface

// File: src/spdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdq_cell
// one position of the ordered chain; entries sorted by level, then queue order
// ----------------------------------------------------------------------------
module spdq_cell #(
    parameter int HANDLE_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spdq_pkg::cell_cmd_t      cmd,
    input  logic                     step,       // a shift/remove pass happens
    // left neighbor (toward head)
    input  logic                     l_valid,
    input  logic [1:0]               l_level,
    input  logic [HANDLE_BITS-1:0]   l_handle,
    input  logic [7:0]               l_tag,
    // right neighbor (toward tail)
    input  logic                     r_valid,
    input  logic [1:0]               r_level,
    input  logic [HANDLE_BITS-1:0]   r_handle,
    input  logic [7:0]               r_tag,
    input  logic                     r_kill,     // removal here or to our left shifts us
    input  logic                     new_first,  // this cell is first after insert
    input  logic [HANDLE_BITS-1:0]   new_handle,
    output logic                     valid,
    output logic [1:0]               level,
    output logic [HANDLE_BITS-1:0]   handle,
    output logic [7:0]               tag,
    output logic                     stay,       // stays in place on insert
    output logic                     kill        // matches the cancel in this pass
);
    import spdq_pkg::*;

    logic                   valid_reg, valid_next;
    logic [1:0]             level_reg, level_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [7:0]             tag_reg, tag_next;

    assign valid  = valid_reg;
    assign level  = level_reg;
    assign handle = handle_reg;
    assign tag    = tag_reg;

    // insert point: front goes ahead of the first entry of level >= lv,
    // back ahead of the first entry of level > lv
    assign stay = valid_reg &&
        ((cmd.ins_front && level_reg < cmd.level) ||
         (cmd.ins_back  && level_reg <= cmd.level));
    // every match flags; the controller shifts out only the first one per pass
    assign kill = valid_reg && cmd.cancel && level_reg == cmd.level &&
                  tag_reg == cmd.tag;

    always_comb
    begin
        valid_next  = valid_reg;
        level_next  = level_reg;
        handle_next = handle_reg;
        tag_next    = tag_reg;
        if (step)
        begin
            if (cmd.ins_front || cmd.ins_back)
            begin
                if (!stay)
                begin
                    if (new_first)
                    begin
                        valid_next  = 1'b1;
                        level_next  = cmd.level;
                        handle_next = new_handle;
                        tag_next    = cmd.tag;
                    end
                    else
                    begin
                        valid_next  = l_valid;
                        level_next  = l_level;
                        handle_next = l_handle;
                        tag_next    = l_tag;
                    end
                end
            end
            else if (r_kill)
            begin
                valid_next  = r_valid;
                level_next  = r_level;
                handle_next = r_handle;
                tag_next    = r_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        level_reg  <= level_next;
        handle_reg <= handle_next;
        tag_reg    <= tag_next;
    end
endmodule

// File: src/strict_priority_deque_with_cancel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_deque_with_cancel_core
// strict priority deque with cancel by tag, built as a sorted cell chain
// ----------------------------------------------------------------------------
// usage
//   req channel carries one operation: push back, push front, pop or cancel
//   rsp channel returns one result per request in request order
//   entries live in a chain of POOL_DEPTH cells kept sorted by level, then
//   by queue order, so the head of the chain is always the next pop
//   push and pop go from the accepting edge through the work state straight to response valid
//   cancel removes one matching entry per cycle in a shift pass and stays
//   in the work state until no entry matches, then raises response valid
//   the request side is held off while an operation is in flight; a new
//   request is taken the cycle after the response transaction, so the
//   core takes no new request before the last one has been answered
//   reset empties every level and clears the response register
//   when the receiver stalls the response stays in the output register and
//   the next request is not taken until it leaves
// ----------------------------------------------------------------------------
module strict_priority_deque_with_cancel_core #(
    parameter int HANDLE_BITS = spdq_pkg::HANDLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spdq_req_if.sink   req,
    spdq_rsp_if.source rsp
);
    import spdq_pkg::*;

    localparam int NUM_LEVELS = NUM_LEVELS_DEF;
    localparam int POOL_DEPTH = POOL_DEPTH_DEF;
    localparam int CNT_BITS   = $clog2(POOL_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_WORK, S_RESP} state_t;

    state_t                 state_reg;
    cell_cmd_t              cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [4:0]             removed_reg;
    logic                   is_pop_reg, is_pop_next;

    // response fields decided when a request is accepted
    logic [STATUS_BITS-1:0] acc_status;
    logic                   acc_got;
    logic [HANDLE_BITS-1:0] acc_handle;
    logic [1:0]             acc_level;

    logic [POOL_DEPTH-1:0]  c_valid, c_stay, c_kill, c_first, c_rkill;
    logic [1:0]             c_level  [POOL_DEPTH];
    logic [HANDLE_BITS-1:0] c_handle [POOL_DEPTH];
    logic [7:0]             c_tag    [POOL_DEPTH];
    logic                   step;
    logic                   any_kill;

    // first kill and every cell to the right of it shift left by one
    always_comb
    begin
        c_rkill[0] = c_kill[0];
        for (int i = 1; i < POOL_DEPTH; i++)
            c_rkill[i] = c_kill[i] || c_rkill[i-1];
    end
    assign any_kill = |c_kill;

    always_comb
    begin
        c_first[0] = !c_stay[0];
        for (int i = 1; i < POOL_DEPTH; i++)
            c_first[i] = !c_stay[i] && c_stay[i-1];
    end

    // cell i takes right neighbor when it is at or past the first kill
    genvar g;
    for (g = 0; g < POOL_DEPTH; g++)
    begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == POOL_DEPTH - 1) ? g : g + 1;
        spdq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd_reg), .step(step),
            .l_valid(g == 0 ? 1'b0 : c_valid[L]), .l_level(c_level[L]),
            .l_handle(c_handle[L]), .l_tag(c_tag[L]),
            .r_valid(g == POOL_DEPTH - 1 ? 1'b0 : c_valid[R]), .r_level(c_level[R]),
            .r_handle(c_handle[R]), .r_tag(c_tag[R]),
            .r_kill(c_rkill[g]), .new_first(c_first[g]), .new_handle(hnd_reg),
            .valid(c_valid[g]), .level(c_level[g]), .handle(c_handle[g]),
            .tag(c_tag[g]), .stay(c_stay[g]), .kill(c_kill[g])
        );
    end

    // pop reuses the removal path with the head's own level and tag
    assign step = (state_reg == S_WORK) &&
                  (cmd_reg.ins_front || cmd_reg.ins_back || any_kill);

    assign req.ready = (state_reg == S_IDLE);

    // decode of the request on the channel
    always_comb
    begin
        cmd_next       = '0;
        cmd_next.level = req.level;
        cmd_next.tag   = req.tag_key;
        count_next     = count_reg;
        is_pop_next    = 1'b0;
        acc_status     = ST_DONE;
        acc_got        = 1'b0;
        acc_handle     = '0;
        acc_level      = '0;
        case (req_type_t'(req.req_type))
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
            begin
                if (32'(req.level) < NUM_LEVELS)
                begin
                    if (32'(count_reg) == POOL_DEPTH)
                        acc_status = ST_FULL;
                    else
                    begin
                        cmd_next.ins_back  = (req.req_type == REQ_PUSH_BACK);
                        cmd_next.ins_front = (req.req_type == REQ_PUSH_FRONT);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            REQ_POP:
            begin
                is_pop_next = 1'b1;
                if (c_valid[0])
                begin
                    // match head exactly by its own level and tag
                    cmd_next.cancel   = 1'b1;
                    cmd_next.pop_head = 1'b1;
                    cmd_next.level    = c_level[0];
                    cmd_next.tag      = c_tag[0];
                    acc_got    = 1'b1;
                    acc_handle = c_handle[0];
                    acc_level  = c_level[0];
                    count_next = count_reg - 1'b1;
                end
                else
                    acc_status = ST_EMPTY;
            end
            default:
            begin
                if (32'(req.level) < NUM_LEVELS)
                    cmd_next.cancel = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            count_reg   <= '0;
            removed_reg <= '0;
            is_pop_reg  <= 1'b0;
            hnd_reg     <= '0;
            rsp.valid   <= 1'b0;
            rsp.status  <= ST_DONE;
            rsp.got_entry  <= 1'b0;
            rsp.out_handle <= '0;
            rsp.out_level  <= '0;
            rsp.removed    <= '0;
            rsp.occupancy  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg        <= cmd_next;
                        removed_reg    <= '0;
                        is_pop_reg     <= is_pop_next;
                        hnd_reg        <= req.handle;
                        count_reg      <= count_next;
                        rsp.status     <= acc_status;
                        rsp.got_entry  <= acc_got;
                        rsp.out_handle <= acc_handle;
                        rsp.out_level  <= acc_level;
                        state_reg      <= S_WORK;
                    end
                end
                S_WORK:
                begin
                    if (cmd_reg.pop_head || !(cmd_reg.cancel && any_kill))
                    begin
                        state_reg <= S_RESP;
                        rsp.valid <= 1'b1;
                        rsp.removed   <= (cmd_reg.cancel && !is_pop_reg) ?
                                         removed_reg : 5'd0;
                        rsp.occupancy <= 5'(count_reg);
                    end
                    else
                    begin
                        removed_reg <= removed_reg + 1'b1;
                        count_reg   <= count_reg - 1'b1;
                    end
                end
                default:
                begin
                    if (rsp.ready)
                    begin
                        rsp.valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // occupancy never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= POOL_DEPTH)
        else $error("occupancy overflow");

    // no request is taken while a response is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken with response pending");

    // a popped entry always reports done
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.got_entry) |-> rsp.status == ST_DONE)
        else $error("pop status mismatch");
endmodule

// File: bench/strict_priority_deque_with_cancel_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_deque_with_cancel_core_tb
// drives push, pop and cancel requests into the priority deque with random
// idling on both channels, predicts each response from a queue model
// of the levels and checks every response field in order
// ----------------------------------------------------------------------------

// keeps a model of the per-level lists and the responses still owed
class deque_scoreboard;
    typedef struct packed {
        logic [1:0] status;
        logic       got_entry;
        logic [7:0] out_handle;
        logic [1:0] out_level;
        logic [4:0] removed;
        logic [4:0] occupancy;
    } deque_rsp_t;

    typedef struct packed {
        logic [7:0] handle;
        logic [7:0] tag;
    } slot_t;

    slot_t      level_list[4][$];
    deque_rsp_t owed_rsp[$];
    int         mismatches;
    int         checked;

    function new();
        mismatches = 0;
        checked    = 0;
    endfunction

    function int occupancy_now();
        int n;
        n = 0;
        for (int i = 0; i < 4; i++)
            n += level_list[i].size();
        return n;
    endfunction

    // work out the response of one accepted request and update the lists
    function void note_request(spdq_pkg::req_type_t op, logic [1:0] lv,
                               logic [7:0] hd, logic [7:0] tg);
        deque_rsp_t r;
        slot_t      e;
        slot_t      kept[$];
        r = '0;
        e.handle = hd;
        e.tag    = tg;
        case (op)
            spdq_pkg::REQ_PUSH_BACK, spdq_pkg::REQ_PUSH_FRONT:
            begin
                if (occupancy_now() >= 16)
                    r.status = spdq_pkg::ST_FULL;
                else if (op == spdq_pkg::REQ_PUSH_BACK)
                    level_list[lv].push_back(e);
                else
                    level_list[lv].push_front(e);
            end
            spdq_pkg::REQ_POP:
            begin
                r.status = spdq_pkg::ST_EMPTY;
                for (int i = 0; i < 4; i++)
                begin
                    if (level_list[i].size() > 0)
                    begin
                        e = level_list[i].pop_front();
                        r.status     = spdq_pkg::ST_DONE;
                        r.got_entry  = 1'b1;
                        r.out_handle = e.handle;
                        r.out_level  = i[1:0];
                        break;
                    end
                end
            end
            default:
            begin
                foreach (level_list[lv][k])
                    if (level_list[lv][k].tag == tg)
                        r.removed++;
                    else
                        kept.push_back(level_list[lv][k]);
                level_list[lv] = kept;
            end
        endcase
        r.occupancy = 5'(occupancy_now());
        owed_rsp.push_back(r);
    endfunction

    // compare one response with the oldest owed one
    task check_response(deque_rsp_t got);
        deque_rsp_t w;
        checked++;
        if (owed_rsp.size() == 0)
        begin
            $display("ERROR: response with nothing owed %p", got);
            mismatches++;
            return;
        end
        w = owed_rsp.pop_front();
        if (got.status != w.status)         report("status", got.status, w.status);
        if (got.got_entry != w.got_entry)   report("got_entry", got.got_entry, w.got_entry);
        if (got.out_handle != w.out_handle) report("out_handle", got.out_handle, w.out_handle);
        if (got.out_level != w.out_level)   report("out_level", got.out_level, w.out_level);
        if (got.removed != w.removed)       report("removed", got.removed, w.removed);
        if (got.occupancy != w.occupancy)   report("occupancy", got.occupancy, w.occupancy);
    endtask

    task report(string field, int got, int want);
        $display("ERROR: response %0d field %s got %0d want %0d", checked, field, got, want);
        mismatches++;
    endtask
endclass

module strict_priority_deque_with_cancel_core_tb;
    import spdq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    spdq_req_if #(.HANDLE_BITS(8)) req ();
    spdq_rsp_if #(.HANDLE_BITS(8)) rsp ();

    strict_priority_deque_with_cancel_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    deque_scoreboard deque_sb;
    int  cycle_count;
    bit  idle_free;     // when set neither side idles
    int  op_seen[4];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: ready is updated at the falling edge, responses taken at the rise
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 13);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            deque_sb.check_response({rsp.status, rsp.got_entry, rsp.out_handle,
                                     rsp.out_level, rsp.removed, rsp.occupancy});
    end

    // watchdog over the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one transaction on the request channel, with a random idle gap first
    task automatic send_request(req_type_t op, logic [1:0] lv, logic [7:0] hd,
                                logic [7:0] tg);
        while (!idle_free && $urandom_range(99) < 13)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= op;
        req.level    <= lv;
        req.handle   <= hd;
        req.tag_key  <= tg;
        // wait for the accepting edge
        do
            @(posedge clk);
        while (!req.ready);
        deque_sb.note_request(op, lv, hd, tg);
        op_seen[op]++;
        @(negedge clk);
    endtask

    // let every owed response drain
    task automatic drain_responses();
        req.valid <= 1'b0;
        while (deque_sb.owed_rsp.size() != 0)
            @(negedge clk);
    endtask

    // tags from a small set so cancels find matches
    task automatic random_request(int push_weight);
        int         pick;
        req_type_t  op;
        pick = $urandom_range(99);
        if (pick < push_weight)
            op = ($urandom_range(2) == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        else if (pick < push_weight + (100 - push_weight) * 3 / 4)
            op = REQ_POP;
        else
            op = REQ_CANCEL;
        send_request(op, 2'($urandom_range(3)), 8'($urandom_range(255)),
                     ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                                8'($urandom_range(3)));
    endtask

    initial
    begin
        deque_sb     = new();
        idle_free    = 1'b0;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.req_type = REQ_PUSH_BACK;
        req.level    = '0;
        req.handle   = '0;
        req.tag_key  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: pop on an empty pool, cancel on an empty level
        send_request(REQ_POP, 2'd0, 8'hff, 8'hff);
        send_request(REQ_CANCEL, 2'd3, 8'h00, 8'h00);
        // extremes of handle and tag, both push kinds, front ahead of back
        send_request(REQ_PUSH_BACK, 2'd3, 8'hff, 8'hff);
        send_request(REQ_PUSH_FRONT, 2'd3, 8'h00, 8'h00);
        send_request(REQ_PUSH_BACK, 2'd0, 8'h5a, 8'h11);
        // cancel with no match, then one that removes the tag ff entry of level three
        send_request(REQ_CANCEL, 2'd0, 8'h00, 8'h22);
        send_request(REQ_CANCEL, 2'd3, 8'h00, 8'hff);
        // fill the pool past its size so that the last pushes are refused
        for (int i = 0; i < 15; i++)
            send_request(REQ_PUSH_BACK, i[1:0], 8'(i * 17), 8'(i % 2));
        send_request(REQ_PUSH_FRONT, 2'd1, 8'ha5, 8'h01);
        // cancel tag one on level one, which every entry left in that level carries
        send_request(REQ_CANCEL, 2'd1, 8'h00, 8'h01);
        // hold off until the directed part has fully answered
        drain_responses();

        // random: long stretch with no idling, then normal idling
        idle_free = 1'b1;
        for (int n = 0; n < 200; n++)
            random_request(50);
        idle_free = 1'b0;
        for (int n = 0; n < 950; n++)
            random_request((n / 100) % 2 ? 65 : 35);

        drain_responses();
        repeat (40) @(negedge clk);
        $display("covered %0d push back, %0d push front, %0d pop, %0d cancel requests",
                 op_seen[REQ_PUSH_BACK], op_seen[REQ_PUSH_FRONT], op_seen[REQ_POP],
                 op_seen[REQ_CANCEL]);
        $display("checked %0d responses, %0d mismatches", deque_sb.checked,
                 deque_sb.mismatches);
        if (deque_sb.mismatches == 0 && deque_sb.owed_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
